@@ rtl/core/sse_pkg.sv @@
// Shared constants for the shell sort engine.
`default_nettype none
package sse_pkg;
    // floor(g / 3) == (g * DIV3_RECIP) >> DIV3_SHIFT for every g below 512
    localparam int DIV3_RECIP = 171;
    localparam int DIV3_SHIFT = 9;
    localparam int DIV3_XW    = 8;
endpackage
`default_nettype wire

@@ rtl/core/sse_ram.sv @@
// Element store: one write port, one read port, registered read data.
`default_nettype none
module sse_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [DATA_WIDTH-1:0]         wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic      [DATA_WIDTH-1:0]         rd_data
);
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/shell_sort_engine_top.sv @@
// Shell sort engine top level: load, gapped insertion passes, sorted readout.
//
//  channel | dir | fields (tdata low bit up)              | tlast
//  s_*     | in  | value[DATA_WIDTH-1:0]                  | last_item
//  m_*     | out | sorted_value[DATA_WIDTH-1:0]           | last_out
//
// Load: one cycle per transfer; s_tready is high only while loading.
// Sort: the gap grows as 3g+1 until it reaches the item count, then each pass
// divides it by three and inserts every element: read it, then compare and shift
// one neighbour at a time, then write it into place, all bound by the single read and write port of the store.
// Readout: one result at a time, the next read waiting for m_tready to take it.
// Reset clears control and output registers; the store needs no clearing pass.
`default_nettype none
module shell_sort_engine_top
    import sse_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]      s_tdata,  // value
    input  wire logic                                 s_tlast,  // last_item
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [((DATA_WIDTH+7)/8)*8-1:0]      m_tdata,  // sorted_value
    output logic                                      m_tlast   // last_out
);
    localparam int TD_W   = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int GAP_W  = CNT_W + 2;
    localparam int PROD_W = GAP_W + DIV3_XW;

    typedef enum logic [3:0] {
        S_LOAD, S_GROW, S_DIV, S_START, S_HOLD, S_CMP, S_PLACE, S_OUT_RD, S_OUT_WAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [CNT_W-1:0]       i_reg, i_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [GAP_W-1:0]       gap_reg, gap_next;
    logic [DATA_WIDTH-1:0]  held_reg, held_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_last_reg, m_last_next;
    logic [DATA_WIDTH-1:0]  m_data_reg, m_data_next;

    logic                   wr_en, rd_en;
    logic [ADDR_W-1:0]      wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0]  wr_data, rd_data;

    logic [GAP_W-1:0]       gap_grow, gap_third, pos_w, i_w, n_w, np_w;
    logic [PROD_W-1:0]      gap_prod;
    logic                   held_less;

    sse_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign gap_grow  = GAP_W'(3) * gap_reg + GAP_W'(1);
    assign gap_prod  = PROD_W'(gap_reg) * PROD_W'(DIV3_RECIP);
    assign gap_third = GAP_W'(gap_prod >> DIV3_SHIFT);
    assign pos_w     = GAP_W'(pos_reg);
    assign i_w       = GAP_W'(i_reg);
    assign n_w       = GAP_W'(n_reg);
    assign np_w      = pos_w - gap_reg;
    assign held_less = $signed(held_reg) < $signed(rd_data);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        gap_next     = gap_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_last_next  = m_last_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg[ADDR_W-1:0];
        wr_data      = held_reg;
        rd_en        = 1'b0;
        rd_addr      = i_reg[ADDR_W-1:0];

        case (state_reg)
            S_LOAD:
            begin
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_data = s_tdata[DATA_WIDTH-1:0];
                if (s_tvalid)
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (s_tlast || (cnt_reg == CNT_W'(DEPTH - 1)))
                    begin
                        n_next     = cnt_reg + CNT_W'(1);
                        gap_next   = GAP_W'(1);
                        state_next = S_GROW;
                    end
                end
            end
            S_GROW:
            begin
                gap_next = gap_grow;
                if (gap_grow >= n_w)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                gap_next   = gap_third;
                i_next     = CNT_W'(gap_third);
                state_next = S_START;
            end
            S_START:
            begin
                if (i_reg >= n_reg)
                begin
                    if (gap_reg > GAP_W'(1))
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_OUT_RD;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[ADDR_W-1:0];
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                held_next = rd_data;
                pos_next  = i_reg;
                if (i_w >= gap_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(i_w - gap_reg);
                    state_next = S_CMP;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_START;
                end
            end
            S_CMP:
            begin
                wr_en = 1'b1;
                if (held_less)
                begin
                    wr_data  = rd_data;
                    pos_next = CNT_W'(np_w);
                    if (np_w >= gap_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_W'(np_w - gap_reg);
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_START;
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                i_next     = i_reg + CNT_W'(1);
                state_next = S_START;
            end
            S_OUT_RD:
            begin
                if (!m_valid_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg[ADDR_W-1:0];
                    state_next = S_OUT_WAIT;
                end
            end
            S_OUT_WAIT:
            begin
                m_valid_next = 1'b1;
                m_data_next  = rd_data;
                m_last_next  = (k_reg + CNT_W'(1)) == n_reg;
                k_next       = k_reg + CNT_W'(1);
                if ((k_reg + CNT_W'(1)) == n_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            n_reg       <= '0;
            i_reg       <= '0;
            pos_reg     <= '0;
            k_reg       <= '0;
            gap_reg     <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            pos_reg     <= pos_next;
            k_reg       <= k_next;
            gap_reg     <= gap_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TD_W'(m_data_reg);
    assign m_tlast  = m_last_reg;

    a_cmp_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (pos_w >= gap_reg))
        else $error("compare with pos below gap");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT_WAIT) |-> !m_valid_reg)
        else $error("output register overwritten");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready)
            |=> (m_valid_reg && $stable(m_data_reg) && $stable(m_last_reg)))
        else $error("stalled result changed");

    a_gap_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START || state_reg == S_HOLD || state_reg == S_CMP)
            |-> (gap_reg != '0))
        else $error("zero gap in pass");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (cnt_reg < CNT_W'(DEPTH)))
        else $error("load count overflow");
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the shell sort engine: random sets, sorted-order scoreboard.
module testbench;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 120;

    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    class sort_scoreboard;
        typedef struct packed {
            logic [DATA_WIDTH-1:0] sorted_value;
            logic                  last_out;
        } sorted_item_t;

        logic [DATA_WIDTH-1:0] open_set[$];
        sorted_item_t          sorted_queue[$];
        int unsigned           mismatches;

        function new();
            mismatches = 0;
        endfunction

        // loaded value; closes the set on last_item or a full store
        function void note_value(logic [DATA_WIDTH-1:0] v, logic last_item);
            int n;
            int j;
            logic [DATA_WIDTH-1:0] held;
            sorted_item_t entry;
            open_set.push_back(v);
            if (!last_item && open_set.size() < DEPTH)
                return;
            n = open_set.size();
            for (int i = 1; i < n; i++)
            begin
                held = open_set[i];
                j = i;
                while (j > 0 && $signed(open_set[j-1]) > $signed(held))
                begin
                    open_set[j] = open_set[j-1];
                    j--;
                end
                open_set[j] = held;
            end
            for (int k = 0; k < n; k++)
            begin
                entry.sorted_value = open_set[k];
                entry.last_out     = (k == n - 1);
                sorted_queue.push_back(entry);
            end
            open_set.delete();
        endfunction

        function void check_result(logic [DATA_WIDTH-1:0] v, logic last_out);
            sorted_item_t want;
            if (sorted_queue.size() == 0)
            begin
                $error("unexpected transfer: sorted_value %h last_out %b", v, last_out);
                mismatches++;
                return;
            end
            want = sorted_queue.pop_front();
            if (v !== want.sorted_value)
            begin
                $error("sorted_value: expected %h, actual %h", want.sorted_value, v);
                mismatches++;
            end
            if (last_out !== want.last_out)
            begin
                $error("last_out: expected %b, actual %b", want.last_out, last_out);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    sort_scoreboard sb;
    int unsigned    burst_left;
    int unsigned    items_sent;

    shell_sort_engine_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // transfers are sampled with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_value(s_tdata[DATA_WIDTH-1:0], s_tlast);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[DATA_WIDTH-1:0], m_tlast);
    end

    // sink backpressure: mostly ready, short stalls, rare long stalls, free-run stretches
    initial
    begin
        int r;
        int run_len;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                run_len = $urandom_range(20, 80);
                m_tready <= 1'b1;
            end
            else if (r < 15)
            begin
                run_len = $urandom_range(10, 50);
                m_tready <= 1'b0;
            end
            else
            begin
                run_len = 1;
                m_tready <= (r < 75);
            end
            repeat (run_len) @(posedge clk);
        end
    end

    function automatic int unsigned pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom();
        if (r < 75)
            return DATA_WIDTH'($signed($urandom_range(0, 8)) - 4);
        if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0: return MAX_VAL;
                1: return MIN_VAL;
                2: return '0;
                3: return '1;
                default: return DATA_WIDTH'(1);
            endcase
        end
        if (r < 93)
            return MAX_VAL - DATA_WIDTH'($urandom_range(0, 3));
        return MIN_VAL + DATA_WIDTH'($urandom_range(0, 3));
    endfunction

    // called at a rising edge; returns at the edge where the transfer happens
    task automatic send_item(input logic [DATA_WIDTH-1:0] v, input logic last_item);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(v);
        s_tlast  <= last_item;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_set(input int n, input logic last_on_final);
        for (int i = 0; i < n; i++)
            send_item(pick_value(), (i == n - 1) ? last_on_final : 1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.sorted_queue.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int r;
        sb = new();
        burst_left = 0;
        items_sent = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and duplicates in one set
        send_item(MAX_VAL, 1'b0);
        send_item(MIN_VAL, 1'b0);
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item(DATA_WIDTH'(1), 1'b0);
        send_item(MAX_VAL, 1'b0);
        send_item(MIN_VAL, 1'b1);
        // single-element sets
        send_item(MIN_VAL, 1'b1);
        send_item(MAX_VAL, 1'b1);
        // two elements, reversed
        send_item(DATA_WIDTH'(5), 1'b0);
        send_item(DATA_WIDTH'(-5), 1'b1);
        // already ascending
        for (int i = 0; i < 4; i++)
            send_item(DATA_WIDTH'(i * 3 - 4), i == 3);
        // strictly descending
        for (int i = 0; i < 5; i++)
            send_item(DATA_WIDTH'(1000 - i * 700), i == 4);

        // hold off until every sorted result is out
        wait_drained();

        // full store with last_item never set
        send_set(DEPTH, 1'b0);
        while (items_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_set($urandom_range(1, 6), 1'b1);
            else
                send_set($urandom_range(7, 20), 1'b1);
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.sorted_queue.size() == 0 && sb.open_set.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ shell_sort_engine_top.f @@
rtl/core/sse_pkg.sv
rtl/core/sse_ram.sv
rtl/core/shell_sort_engine_top.sv
sim/testbench.sv
